>>> hw/rtl/srlp_pkg.sv
// Shared types, constants and codes for the sensor reply line parser.
package srlp_pkg;

  // Reply line buffer length in bytes (at least 11).
  localparam int LINE_BYTES = 16;
  localparam int LCNT_W     = $clog2(LINE_BYTES + 1);

  // Results that may wait between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CR_BYTE = 8'h0D;

  localparam logic [23:0] TXT_OEM   = "OEM";
  localparam logic [31:0] TXT_USER  = "USER";
  localparam logic [31:0] TXT_INIT  = "INIT";
  localparam logic [39:0] TXT_ZERO2 = "ZERO2";
  localparam logic [31:0] TXT_CALB  = "CALB";
  localparam logic [39:0] TXT_AZERO = "AZERO";
  localparam logic [15:0] TXT_OK    = "OK";

  // Offsets of the OK tag for the commands that carry one.
  localparam int OK_POS_INIT  = 5;
  localparam int OK_POS_ZERO2 = 6;
  localparam int OK_POS_CALB  = 9;

  // Awaited command codes.
  localparam logic [2:0] CMD_PASSWORD = 3'd0;
  localparam logic [2:0] CMD_ID       = 3'd1;
  localparam logic [2:0] CMD_RT       = 3'd2;
  localparam logic [2:0] CMD_SERIAL   = 3'd3;
  localparam logic [2:0] CMD_OTHER    = 3'd4;

  typedef enum logic [3:0] {
    KIND_OEM     = 4'd0,
    KIND_USER    = 4'd1,
    KIND_INIT    = 4'd2,
    KIND_ZERO2   = 4'd3,
    KIND_CALB    = 4'd4,
    KIND_AZERO   = 4'd5,
    KIND_MEAS    = 4'd6,
    KIND_IDRT    = 4'd7,
    KIND_SERIAL  = 4'd8,
    KIND_UNKNOWN = 4'd9
  } kind_e;

  // One classified line: verdict plus the first eight bytes as big-endian words.
  typedef struct packed {
    kind_e            kind;
    logic             ok;
    logic [3:0][15:0] words;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

>>> hw/rtl/sensor_reply_line_parser_core.sv
// Top level of the sensor reply line parser.
//
// Input stream: one received byte per transfer (s_axis_*). Bytes are collected into
// a LINE_BYTES line buffer; bytes beyond its end are dropped. A 0x0D byte ends
// the line, which is then classified against the awaited command carried
// alongside it (OEM, USER, INIT/ZERO2/CALB with OK tag, AZERO, XOR-checked
// measurement frame, ID/RT, serial query, else error).
// Output stream: one result transfer per 0x0D, none for other bytes. It carries
// the verdict, the reply kind and the current measurement and serial registers.
// Config: cfg_we_i loads the 16-bit state error mask (reset value 1).
// Throughput: one byte per cycle while the queue has room; the line is classified
// combinationally from the buffer contents in parallel.
// Result path: the result is written into the queue on the 0x0D transfer, then
// loaded into the output register once that register is free.
// Stall: a two-entry queue sits between classifier and output register, so
// bytes keep flowing while a result waits; once the queue is full s_axis_tready_o
// drops until the receiver takes a result.
// Reset: line buffer, counters, registers and queue clear; mask returns to 1.
module sensor_reply_line_parser_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // [7:0] rx_byte, [10:8] pending_command, [15:11] zero
  input  logic [15:0]   s_axis_tdata_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // [0] status_ok, [4:1] response_kind, [20:5] gas_value, [36:21] sensor_state,
  // [37] sensor_error, [53:38] serial_word0, [69:54] serial_word1,
  // [85:70] serial_word2, [101:86] serial_word3, [103:102] zero
  output logic [103:0]  m_axis_tdata_o,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i
);

  logic             in_xfer;
  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             pop;
  srlp_pkg::rec_t   front_rec;
  srlp_pkg::rec_t   q_rec;

  // Ready does not look at the data: any byte may be a CR needing a queue slot.
  assign s_axis_tready_o = !q_full;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  srlp_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (in_xfer),
    .rx_byte_i         (s_axis_tdata_i[7:0]),
    .pending_command_i (s_axis_tdata_i[10:8]),
    .push_o            (push),
    .rec_o             (front_rec)
  );

  srlp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (front_rec),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rec_o   (q_rec)
  );

  srlp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_rec_i     (q_rec),
    .pop_o       (pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

>>> hw/rtl/srlp_front.sv
// Front part: collects reply bytes into the line buffer and classifies a line at CR.
module srlp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [2:0]       pending_command_i,
  output logic             push_o,
  output srlp_pkg::rec_t   rec_o
);

  logic [srlp_pkg::LINE_BYTES-1:0][7:0] line_q, line_d, view;
  logic [srlp_pkg::LCNT_W-1:0]          count_q, count_d;
  logic [2:0]                           cmd;
  logic                                 is_cr;

  // Line as it stands with the current byte written in.
  always_comb begin
    for (int j = 0; j < srlp_pkg::LINE_BYTES; j++) begin
      view[j] = (count_q == srlp_pkg::LCNT_W'(j)) ? rx_byte_i : line_q[j];
    end
  end

  assign is_cr = (rx_byte_i == srlp_pkg::CR_BYTE);
  assign cmd   = (pending_command_i > srlp_pkg::CMD_OTHER) ? srlp_pkg::CMD_OTHER
                                                           : pending_command_i;

  always_comb begin
    rec_o.ok    = 1'b1;
    rec_o.kind  = srlp_pkg::KIND_UNKNOWN;
    rec_o.words = {view[6], view[7], view[4], view[5], view[2], view[3], view[0], view[1]};
    if ({view[0], view[1], view[2]} == srlp_pkg::TXT_OEM) begin
      rec_o.kind = srlp_pkg::KIND_OEM;
    end else if ({view[0], view[1], view[2], view[3]} == srlp_pkg::TXT_USER) begin
      rec_o.kind = srlp_pkg::KIND_USER;
      rec_o.ok   = (cmd != srlp_pkg::CMD_PASSWORD);
    end else if ({view[0], view[1], view[2], view[3]} == srlp_pkg::TXT_INIT) begin
      rec_o.kind = srlp_pkg::KIND_INIT;
      rec_o.ok   = ({view[srlp_pkg::OK_POS_INIT], view[srlp_pkg::OK_POS_INIT+1]}
                    == srlp_pkg::TXT_OK);
    end else if ({view[0], view[1], view[2], view[3], view[4]} == srlp_pkg::TXT_ZERO2) begin
      rec_o.kind = srlp_pkg::KIND_ZERO2;
      rec_o.ok   = ({view[srlp_pkg::OK_POS_ZERO2], view[srlp_pkg::OK_POS_ZERO2+1]}
                    == srlp_pkg::TXT_OK);
    end else if ({view[0], view[1], view[2], view[3]} == srlp_pkg::TXT_CALB) begin
      rec_o.kind = srlp_pkg::KIND_CALB;
      rec_o.ok   = ({view[srlp_pkg::OK_POS_CALB], view[srlp_pkg::OK_POS_CALB+1]}
                    == srlp_pkg::TXT_OK);
    end else if ({view[0], view[1], view[2], view[3], view[4]} == srlp_pkg::TXT_AZERO) begin
      rec_o.kind = srlp_pkg::KIND_AZERO;
    end else if ((view[0] ^ view[1] ^ view[2] ^ view[3]) == view[4]) begin
      rec_o.kind = srlp_pkg::KIND_MEAS;
    end else if (cmd == srlp_pkg::CMD_ID || cmd == srlp_pkg::CMD_RT) begin
      rec_o.kind = srlp_pkg::KIND_IDRT;
    end else if (cmd == srlp_pkg::CMD_SERIAL) begin
      rec_o.kind = srlp_pkg::KIND_SERIAL;
    end else begin
      rec_o.ok   = 1'b0;
    end
  end

  assign push_o = accept_i && is_cr;

  // Bytes past the end of the buffer are dropped; CR clears the line.
  always_comb begin
    line_d  = line_q;
    count_d = count_q;
    if (accept_i) begin
      if (is_cr) begin
        line_d  = '0;
        count_d = '0;
      end else begin
        line_d = view;
        if (count_q < srlp_pkg::LCNT_W'(srlp_pkg::LINE_BYTES)) begin
          count_d = count_q + srlp_pkg::LCNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q  <= '0;
      count_q <= '0;
    end else begin
      line_q  <= line_d;
      count_q <= count_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= srlp_pkg::LCNT_W'(srlp_pkg::LINE_BYTES))
    else $error("line count past buffer end");
  a_cr_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (count_q == '0) && (line_q == '0))
    else $error("line not cleared after CR");
`endif

endmodule

>>> hw/rtl/srlp_queue.sv
// Short queue of classified lines between the front and back parts.
module srlp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  srlp_pkg::rec_t   rec_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output srlp_pkg::rec_t   rec_o
);

  srlp_pkg::rec_t                 mem_q [srlp_pkg::QUEUE_DEPTH];
  logic [srlp_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [srlp_pkg::QCNT_W-1:0]    count_q, count_d;
  logic                           do_push, do_pop;

  assign full_o  = (count_q == srlp_pkg::QCNT_W'(srlp_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign rec_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + srlp_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - srlp_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == srlp_pkg::QPTR_W'(srlp_pkg::QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_q + srlp_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == srlp_pkg::QPTR_W'(srlp_pkg::QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_q + srlp_pkg::QPTR_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= srlp_pkg::QCNT_W'(srlp_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

>>> hw/rtl/srlp_back.sv
// Back part: applies a classified line to the sensor registers and holds the result.
module srlp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  srlp_pkg::rec_t   q_rec_i,
  output logic             pop_o,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [103:0]     out_data_o
);

  logic                   out_valid_q, out_valid_d;
  logic                   ok_q;
  srlp_pkg::kind_e        kind_q;
  logic [15:0]            value_q, state_q, mask_q;
  logic                   err_q;
  logic [3:0][15:0]       serial_q;

  assign pop_o       = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_d = pop_o || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      kind_q      <= srlp_pkg::KIND_OEM;
      value_q     <= '0;
      state_q     <= '0;
      err_q       <= 1'b0;
      serial_q    <= '0;
      mask_q      <= 16'd1;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      if (pop_o) begin
        ok_q   <= q_rec_i.ok;
        kind_q <= q_rec_i.kind;
        if (q_rec_i.kind == srlp_pkg::KIND_MEAS) begin
          value_q <= q_rec_i.words[0];
          state_q <= q_rec_i.words[1];
          err_q   <= |(q_rec_i.words[1] & mask_q);
        end
        if (q_rec_i.kind == srlp_pkg::KIND_SERIAL) begin
          serial_q <= q_rec_i.words;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {2'b00, serial_q[3], serial_q[2], serial_q[1], serial_q[0],
                        err_q, state_q, value_q, kind_q, ok_q};

`ifndef NO_ASSERTIONS
  a_unknown_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == srlp_pkg::KIND_UNKNOWN) |-> !ok_q)
    else $error("unknown reply marked ok");
`endif

endmodule
